// ----- rtl/mbrc_pkg.sv -----
package mbrc_pkg;

    localparam int MAX_REGS_DEF = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Input queue between intake and execution
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Result status codes
    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // Role of a byte within the reply frame
    typedef enum logic [1:0] {
        K_HEAD  = 2'd0,   // address and function code
        K_COUNT = 2'd1,   // byte count
        K_HIGH  = 2'd2,   // high byte of a register pair
        K_LOW   = 2'd3    // low byte of a register pair
    } t_kind;

    // One classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        t_kind      kind;
        logic [6:0] pair_idx;
        logic       short_frame;
    } t_beat;

    // Absorb one byte into a reflected CRC-16/MODBUS remainder
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/mbrc_front.sv -----
module mbrc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_end,
    output mbrc_pkg::t_beat   o_beat
);

    logic [7:0] r_pos;
    logic [7:0] n_pos;
    logic [7:0] pos_m4;

    assign pos_m4 = r_pos - 8'd4;

    // Classify the byte by its position in the frame
    always_comb begin
        o_beat.data        = i_rx_byte;
        o_beat.frame_end   = i_frame_end;
        o_beat.pair_idx    = pos_m4[7:1];
        o_beat.short_frame = (r_pos < 8'd4);
        if (r_pos < 8'd2) begin
            o_beat.kind = mbrc_pkg::K_HEAD;
        end else if (r_pos == 8'd2) begin
            o_beat.kind = mbrc_pkg::K_COUNT;
        end else if (r_pos[0]) begin
            o_beat.kind = mbrc_pkg::K_HIGH;
        end else begin
            o_beat.kind = mbrc_pkg::K_LOW;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (i_take) begin
            if (i_frame_end) begin
                n_pos = 8'd0;
            end else if (r_pos != 8'hFF) begin
                n_pos = r_pos + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- rtl/mbrc_queue.sv -----
module mbrc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbrc_pkg::t_beat   i_beat,
    input  logic              i_pop,
    output mbrc_pkg::t_beat   o_beat,
    output logic              o_full,
    output logic              o_empty
);

    mbrc_pkg::t_beat                r_q [mbrc_pkg::QDEPTH];
    logic [mbrc_pkg::QAW-1:0]       r_wp;
    logic [mbrc_pkg::QAW-1:0]       r_rp;
    logic [mbrc_pkg::QAW:0]         r_cnt;

    assign o_full  = (r_cnt == (mbrc_pkg::QAW+1)'(mbrc_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_beat  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (mbrc_pkg::QAW+1)'(i_push) - (mbrc_pkg::QAW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// ----- rtl/mbrc_back.sv -----
module mbrc_back #(
    parameter int MAX_REGS = mbrc_pkg::MAX_REGS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_check_en,
    input  mbrc_pkg::t_beat      i_beat,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic                 o_has_value,
    output logic [4:0]           o_reg_index,
    output logic signed [15:0]   o_reg_value,
    output logic                 o_last
);

    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW = $clog2(MAX_REGS + 1);

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_EMIT = 2'b10
    } t_bstate;

    t_bstate         r_state, n_state;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_cnt_byte, n_cnt_byte;
    logic [7:0]      r_held0, n_held0;
    logic [7:0]      r_held1, n_held1;
    logic [7:0]      r_pend, n_pend;
    logic [CW-1:0]   r_stored, n_stored;
    logic [CW-1:0]   r_emit_k, n_emit_k;
    logic [CW-1:0]   r_emit_cnt, n_emit_cnt;
    logic            r_out_vld, n_out_vld;
    logic [1:0]      r_out_status, n_out_status;
    logic            r_out_has, n_out_has;
    logic [CW-1:0]   r_out_idx, n_out_idx;
    logic            r_out_last, n_out_last;
    logic [15:0]     mem [MAX_REGS];
    logic [15:0]     r_mem_q;
    logic            wr;
    logic [CW-1:0]   stored_up;
    logic [CW-1:0]   k_next;
    logic            crc_bad;

    assign o_pop = (r_state == S_RUN) && !i_empty;

    always_comb begin
        n_state      = r_state;
        n_crc        = r_crc;
        n_cnt_byte   = r_cnt_byte;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_pend       = r_pend;
        n_stored     = r_stored;
        n_emit_k     = r_emit_k;
        n_emit_cnt   = r_emit_cnt;
        n_out_vld    = 1'b0;
        n_out_status = r_out_status;
        n_out_has    = r_out_has;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        wr           = 1'b0;
        stored_up    = r_stored;
        crc_bad      = 1'b0;
        k_next       = r_emit_k + CW'(1);

        case (r_state)
            S_RUN: begin
                if (o_pop) begin
                    // trailer window: the byte leaving it joins the CRC
                    if (i_beat.kind != mbrc_pkg::K_HEAD) begin
                        n_crc = mbrc_pkg::crc16_byte(r_crc, r_held0);
                    end
                    n_held0 = r_held1;
                    n_held1 = i_beat.data;
                    if (i_beat.kind == mbrc_pkg::K_COUNT) begin
                        n_cnt_byte = i_beat.data;
                    end
                    if (i_beat.kind == mbrc_pkg::K_HIGH) begin
                        n_pend = i_beat.data;
                    end
                    wr = (i_beat.kind == mbrc_pkg::K_LOW)
                         && (i_beat.pair_idx < r_cnt_byte[7:1])
                         && (r_stored < CW'(MAX_REGS));
                    stored_up = r_stored + CW'(wr);
                    n_stored  = stored_up;
                    crc_bad   = i_check_en && (n_crc != {n_held1, n_held0});

                    if (i_beat.frame_end) begin
                        n_out_has  = 1'b0;
                        n_out_idx  = '0;
                        n_out_last = 1'b1;
                        if (i_beat.short_frame) begin
                            n_out_vld    = 1'b1;
                            n_out_status = mbrc_pkg::ST_SHORT;
                        end else if (crc_bad) begin
                            n_out_vld    = 1'b1;
                            n_out_status = mbrc_pkg::ST_CRC;
                        end else if (stored_up == '0) begin
                            n_out_vld    = 1'b1;
                            n_out_status = mbrc_pkg::ST_GOOD;
                        end else begin
                            n_state    = S_EMIT;
                            n_emit_k   = '0;
                            n_emit_cnt = stored_up;
                        end
                        n_crc      = mbrc_pkg::CRC_INIT;
                        n_cnt_byte = 8'd0;
                        n_held0    = 8'd0;
                        n_held1    = 8'd0;
                        n_pend     = 8'd0;
                        n_stored   = '0;
                    end
                end
            end
            S_EMIT: begin
                n_out_vld    = 1'b1;
                n_out_status = mbrc_pkg::ST_GOOD;
                n_out_has    = 1'b1;
                n_out_idx    = r_emit_k;
                n_out_last   = (k_next == r_emit_cnt);
                n_emit_k     = k_next;
                if (k_next == r_emit_cnt) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[r_stored[AW-1:0]] <= {r_pend, i_beat.data};
        end
        r_mem_q <= mem[r_emit_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_crc      <= mbrc_pkg::CRC_INIT;
            r_cnt_byte <= 8'd0;
            r_held0    <= 8'd0;
            r_held1    <= 8'd0;
            r_pend     <= 8'd0;
            r_stored   <= '0;
            r_emit_k   <= '0;
            r_emit_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_crc      <= n_crc;
            r_cnt_byte <= n_cnt_byte;
            r_held0    <= n_held0;
            r_held1    <= n_held1;
            r_pend     <= n_pend;
            r_stored   <= n_stored;
            r_emit_k   <= n_emit_k;
            r_emit_cnt <= n_emit_cnt;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_has    <= n_out_has;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    assign o_valid     = r_out_vld;
    assign o_status    = r_out_status;
    assign o_has_value = r_out_has;
    assign o_reg_index = 5'(r_out_idx);
    assign o_reg_value = r_out_has ? signed'(r_mem_q) : 16'sd0;
    assign o_last      = r_out_last;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_status != mbrc_pkg::ST_GOOD)) |-> (!r_out_has && r_out_last))
        else $error("error result carries a value or is not last");

    a_emit_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !o_pop)
        else $error("byte taken while emitting values");

    a_burst_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |=> r_out_vld)
        else $error("value burst broken before last");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit_k < r_emit_cnt))
        else $error("emit pointer past stored count");

endmodule

// ----- rtl/modbus_read_response_checker_core.sv -----
// Modbus RTU read-registers reply checker. Feed the reply one byte per beat
// (start high while busy is low) and flag the final byte with i_frame_end.
// A byte is accepted whenever the four-entry input queue has room; the
// execution side drains one byte per cycle while it is not emitting results,
// running CRC-16/MODBUS over everything but the two trailer bytes and storing
// register pairs. At frame end the block emits either one error/empty result
// or every stored value, one per cycle; the queue keeps accepting during that
// walk and busy rises only once it fills.
// Results appear for exactly one cycle under o_result_valid and cannot be
// held off, so the receiver must take them as they come. check_enable may
// only be written while no frame is in flight.
module modbus_read_response_checker_core #(
    parameter int MAX_REGS = mbrc_pkg::MAX_REGS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_end,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    output logic                o_result_valid,
    output logic [1:0]          o_status,
    output logic                o_has_value,
    output logic [4:0]          o_reg_index,
    output logic signed [15:0]  o_reg_value,
    output logic                o_last
);

    logic              r_check_en;
    logic              take;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    mbrc_pkg::t_beat   front_beat;
    mbrc_pkg::t_beat   head_beat;

    // Hold the CRC check enable; reset turns checking on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_check_en <= i_cfg_wdata;
        end
    end

    // Accept a beat whenever the queue has room
    assign busy = q_full;
    assign take = start && !q_full;

    // Front: track frame position and classify each byte
    mbrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_beat      (front_beat)
    );

    // Decouple intake from execution
    mbrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_beat  (front_beat),
        .i_pop   (pop),
        .o_beat  (head_beat),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: CRC, pair decode, value store and result walk
    mbrc_back #(
        .MAX_REGS (MAX_REGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_check_en  (r_check_en),
        .i_beat      (head_beat),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_valid     (o_result_valid),
        .o_status    (o_status),
        .o_has_value (o_has_value),
        .o_reg_index (o_reg_index),
        .o_reg_value (o_reg_value),
        .o_last      (o_last)
    );

endmodule
